// File: rtl/wfq_pkg.sv
// Shared types and constants of the weighted fair queue scheduler.
// No dependencies.
package wfq_pkg;

  localparam int unsigned StatusW = 3;
  localparam int unsigned FtW     = 48;
  localparam int unsigned PtW     = 16;
  localparam int unsigned WeightW = 16;
  localparam int unsigned InIdW   = 8;
  localparam int unsigned InFlowW = 2;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_ENQ    = 3'd0,
    ST_DUP    = 3'd1,
    ST_ABSENT = 3'd2,
    ST_FULL   = 3'd3,
    ST_DEQ    = 3'd4,
    ST_EMPTY  = 3'd5
  } status_e;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  // Command passed from the front end to the back end.
  typedef struct packed {
    logic             op;
    logic [InIdW-1:0] request_id;
    logic [InFlowW-1:0] flow_index;
    logic [PtW-1:0]   processing_time;
  } cmd_t;

endpackage

// File: rtl/wfq_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module wfq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/wfq_front.sv
// Front end: accepts commands into a short command queue.
// Depends on wfq_pkg.
module wfq_front import wfq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  cmd_t cmd_i,
  output logic cmd_valid_o,
  input  logic cmd_take_i,
  output cmd_t cmd_o
);

  cmd_t     buf_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       do_push, do_pop;

  assign full_o      = cnt_q[1];
  assign do_push     = push_i && !full_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign do_pop      = cmd_take_i && cmd_valid_o;
  assign cmd_o       = buf_q[rd_q];

  // Store commands and advance pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wr_q] <= cmd_i;
  end

endmodule

// File: rtl/wfq_back.sv
// Back end: per-flow queues, finish times, iterative divider and result register.
// Depends on wfq_pkg and wfq_ram.
module wfq_back import wfq_pkg::*; #(
  parameter int unsigned NumFlows   = 4,
  parameter int unsigned QueueDepth = 16,
  parameter int unsigned IdBits     = 8,
  parameter int unsigned FracBits   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_take_o,
  input  cmd_t                cmd_i,
  input  logic [WeightW-1:0]  weight_i [NumFlows],
  output logic                empty_o,
  input  logic                pop_i,
  output logic [StatusW-1:0]  status_o,
  output logic [InIdW-1:0]    out_request_id_o,
  output logic [InFlowW-1:0]  out_flow_o,
  output logic [PtW-1:0]      out_processing_time_o
);

  localparam int unsigned FlowW  = (NumFlows > 1) ? $clog2(NumFlows) : 1;
  localparam int unsigned SlotW  = $clog2(QueueDepth);
  localparam int unsigned CntW   = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW  = $clog2(NumFlows * QueueDepth);
  localparam int unsigned NumIds = 1 << IdBits;
  localparam int unsigned EntW   = IdBits + PtW;
  localparam int unsigned DivW   = PtW + FracBits;
  localparam int unsigned DivCntW = $clog2(DivW + 1);
  localparam int unsigned CandW  = FtW + DivW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_DIV, S_NEXT, S_SEND
  } state_e;

  state_e state_q;
  logic [SlotW-1:0]   head_q  [NumFlows];
  logic [CntW-1:0]    count_q [NumFlows];
  logic [FtW-1:0]     ft_q    [NumFlows];
  logic [NumIds-1:0]  used_q;
  logic [FlowW-1:0]   flow_q, best_q;
  logic               found_q;
  logic [CandW-1:0]   best_time_q;
  logic [DivW-1:0]    quo_q;
  logic [WeightW:0]   rem_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [EntW-1:0]    rd_data, ent_q, best_ent_q;
  logic [FlowW-1:0]   rd_flow;
  logic [AddrW-1:0]   raddr, waddr;
  logic               we;
  logic               res_full_q;
  logic [StatusW-1:0] res_st_q;
  logic [InIdW-1:0]   res_id_q;
  logic [InFlowW-1:0] res_flow_q;
  logic [PtW-1:0]     res_pt_q;

  logic [IdBits-1:0]  cmd_id;
  logic               cmd_flow_ok;
  logic [FlowW-1:0]   cmd_flow;
  logic [31:0]        tail_sum;
  logic [WeightW:0]   rem_sh;
  logic [CandW-1:0]   cand;
  logic               flow_live;

  assign cmd_id      = cmd_i.request_id[IdBits-1:0];
  assign cmd_flow_ok = 32'(cmd_i.flow_index) < NumFlows;
  assign cmd_flow    = FlowW'(cmd_i.flow_index);
  assign cmd_take_o  = (state_q == S_IDLE) && !res_full_q;

  // Enqueue writes the tail slot of the command's flow.
  assign we    = cmd_take_o && cmd_valid_i && cmd_i.op == OP_ENQ && !used_q[cmd_id]
                 && cmd_flow_ok && weight_i[cmd_flow] != '0
                 && 32'(count_q[cmd_flow]) < QueueDepth;
  assign tail_sum = 32'(head_q[cmd_flow]) + 32'(count_q[cmd_flow]);
  assign waddr = AddrW'(32'(cmd_flow) * QueueDepth
                 + ((tail_sum >= QueueDepth) ? tail_sum - QueueDepth : tail_sum));

  // Address the head of the flow scanned next, so its data is ready in S_READ.
  assign rd_flow = (state_q == S_IDLE) ? '0
                 : (state_q == S_NEXT && 32'(flow_q) != NumFlows - 1) ? flow_q + 1'b1
                 : flow_q;
  assign raddr = AddrW'(32'(rd_flow) * QueueDepth + 32'(head_q[rd_flow]));

  wfq_ram #(.Width(EntW), .Depth(NumFlows * QueueDepth)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({cmd_id, cmd_i.processing_time}),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  assign flow_live = weight_i[flow_q] != '0 && count_q[flow_q] != '0;
  assign rem_sh    = {rem_q[WeightW-1:0], quo_q[DivW-1]};
  assign cand      = CandW'(ft_q[flow_q]) + CandW'(quo_q);

  assign empty_o               = !res_full_q;
  assign status_o              = res_st_q;
  assign out_request_id_o      = res_id_q;
  assign out_flow_o            = res_flow_q;
  assign out_processing_time_o = res_pt_q;

  // Sequence: enqueue in S_IDLE; for a dequeue, scan flows, divide each head cost by weight, pick the minimum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      res_full_q <= 1'b0;
      found_q    <= 1'b0;
      flow_q     <= '0;
      best_q     <= '0;
      div_cnt_q  <= '0;
      for (int f = 0; f < NumFlows; f++) begin
        head_q[f]  <= '0;
        count_q[f] <= '0;
        ft_q[f]    <= '0;
      end
    end else begin
      if (pop_i && res_full_q) res_full_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_take_o && cmd_valid_i) begin
            if (cmd_i.op == OP_ENQ) begin
              res_full_q <= 1'b1;
              res_id_q   <= '0;
              res_flow_q <= '0;
              res_pt_q   <= '0;
              if (used_q[cmd_id]) begin
                res_st_q <= ST_DUP;
              end else if (!cmd_flow_ok || weight_i[cmd_flow] == '0) begin
                res_st_q <= ST_ABSENT;
              end else if (32'(count_q[cmd_flow]) >= QueueDepth) begin
                res_st_q <= ST_FULL;
              end else begin
                res_st_q <= ST_ENQ;
                used_q[cmd_id] <= 1'b1;
                count_q[cmd_flow] <= count_q[cmd_flow] + 1'b1;
              end
            end else begin
              flow_q  <= '0;
              found_q <= 1'b0;
              state_q <= S_READ;
            end
          end
        end
        S_READ: begin
          // Read data arrives now; skip flows with nothing to offer.
          if (flow_live) begin
            quo_q     <= {rd_data[PtW-1:0], FracBits'(0)};
            ent_q     <= rd_data;
            rem_q     <= '0;
            div_cnt_q <= '0;
            state_q   <= S_DIV;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_DIV: begin
          // One restoring quotient bit per cycle.
          if (rem_sh >= {1'b0, weight_i[flow_q]}) begin
            rem_q <= rem_sh - {1'b0, weight_i[flow_q]};
            quo_q <= {quo_q[DivW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[DivW-2:0], 1'b0};
          end
          if (32'(div_cnt_q) == DivW - 1) begin
            state_q <= S_NEXT;
            div_cnt_q <= '1;
          end else begin
            div_cnt_q <= div_cnt_q + 1'b1;
          end
        end
        S_NEXT: begin
          // div_cnt_q all ones marks a finished division for this flow.
          if (div_cnt_q == '1) begin
            if (!found_q || cand < best_time_q) begin
              found_q     <= 1'b1;
              best_q      <= flow_q;
              best_time_q <= cand;
              best_ent_q  <= ent_q;
            end else if (cand == best_time_q && weight_i[flow_q] > weight_i[best_q]) begin
              best_q     <= flow_q;
              best_ent_q <= ent_q;
            end
          end
          div_cnt_q <= '0;
          if (32'(flow_q) == NumFlows - 1) begin
            state_q <= S_SEND;
          end else begin
            flow_q  <= flow_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_SEND: begin
          state_q    <= S_IDLE;
          res_full_q <= 1'b1;
          if (!found_q) begin
            res_st_q   <= ST_EMPTY;
            res_id_q   <= '0;
            res_flow_q <= '0;
            res_pt_q   <= '0;
          end else begin
            res_st_q   <= ST_DEQ;
            res_id_q   <= InIdW'(best_ent_q[EntW-1:PtW]);
            res_flow_q <= InFlowW'(best_q);
            res_pt_q   <= best_ent_q[PtW-1:0];
            ft_q[best_q] <= (best_time_q > CandW'({FtW{1'b1}})) ? {FtW{1'b1}}
                            : best_time_q[FtW-1:0];
            head_q[best_q]  <= (32'(head_q[best_q]) == QueueDepth - 1) ? '0
                               : head_q[best_q] + 1'b1;
            count_q[best_q] <= count_q[best_q] - 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/weighted_fair_queue_scheduler.sv
// Weighted fair queue scheduler top level.
// An enqueue is answered from the idle state; a dequeue scans every flow in turn,
// dividing each head cost by weight in one shared one-bit-per-cycle divider and skipping
// idle or absent flows. One command at a time is in the back end; the next is taken in
// the cycle after the previous result is popped; two commands buffer in front.
// Reset (rst_ni low, asynchronous) clears queues, finish times, tags and weights.
module weighted_fair_queue_scheduler import wfq_pkg::*; #(
  parameter int unsigned NumFlows   = 4,
  parameter int unsigned QueueDepth = 16,
  parameter int unsigned IdBits     = 8,
  parameter int unsigned FracBits   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               op_i,
  input  logic [InIdW-1:0]   request_id_i,
  input  logic [InFlowW-1:0] flow_index_i,
  input  logic [PtW-1:0]     processing_time_i,
  output logic               empty,
  input  logic               pop,
  output logic [StatusW-1:0] status_o,
  output logic [InIdW-1:0]   out_request_id_o,
  output logic [InFlowW-1:0] out_flow_o,
  output logic [PtW-1:0]     out_processing_time_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WeightW-1:0] cfg_data_i
);

  logic [WeightW-1:0] weight_q [NumFlows];
  cmd_t cmd_in, cmd;
  logic cmd_valid, cmd_take;

  assign cfg_ready_o = 1'b1;

  // Write flow weights; indexes past the flow count are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < NumFlows; f++) weight_q[f] <= '0;
    end else if (cfg_valid_i) begin
      for (int f = 0; f < NumFlows; f++) begin
        if (32'(cfg_index_i) == f) weight_q[f] <= cfg_data_i;
      end
    end
  end

  assign cmd_in = '{op: op_i, request_id: request_id_i, flow_index: flow_index_i,
                    processing_time: processing_time_i};

  wfq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .cmd_i       (cmd_in),
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take),
    .cmd_o       (cmd)
  );

  wfq_back #(
    .NumFlows(NumFlows), .QueueDepth(QueueDepth), .IdBits(IdBits), .FracBits(FracBits)
  ) u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_valid_i           (cmd_valid),
    .cmd_take_o            (cmd_take),
    .cmd_i                 (cmd),
    .weight_i              (weight_q),
    .empty_o               (empty),
    .pop_i                 (pop),
    .status_o              (status_o),
    .out_request_id_o      (out_request_id_o),
    .out_flow_o            (out_flow_o),
    .out_processing_time_o (out_processing_time_o)
  );

endmodule

// File: rtl/wfq_checker.sv
// Port-level checker for the weighted fair queue scheduler, with its bind.
// Depends on wfq_pkg.
module wfq_checker import wfq_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic [StatusW-1:0] status_o,
  input logic [InIdW-1:0]   out_request_id_o,
  input logic [InFlowW-1:0] out_flow_o,
  input logic [PtW-1:0]     out_processing_time_o
);

  // Status codes stay in range.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> status_o <= ST_EMPTY) else $error("bad status");

  // Non-dequeue results carry zero payload.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_DEQ) |-> (out_request_id_o == '0 && out_flow_o == '0
      && out_processing_time_o == '0)) else $error("payload not zero");

  // A waiting result holds until popped.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o))) else $error("result lost");

endmodule

bind weighted_fair_queue_scheduler wfq_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .empty(empty), .pop(pop), .status_o(status_o),
  .out_request_id_o(out_request_id_o), .out_flow_o(out_flow_o),
  .out_processing_time_o(out_processing_time_o)
);

// File: verif/tb_weighted_fair_queue_scheduler.sv
// Self-checking testbench for weighted_fair_queue_scheduler: a directed table of
// transactions, then random phases with varied weights, idling and back-pressure.
// Depends on rtl/wfq_pkg.sv and rtl/weighted_fair_queue_scheduler.sv.
module tb_weighted_fair_queue_scheduler;
  import wfq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NFlows    = 4;
  localparam int unsigned QDepth    = 16;
  localparam int unsigned IdCount   = 256;
  localparam int unsigned Frac      = 16;
  localparam int unsigned Settle    = 200;
  localparam int unsigned CycLimit  = 3000000;
  localparam int unsigned RandItems = 440;
  localparam int unsigned HoldLen   = 400;
  localparam logic [FtW-1:0] FtSat  = '1;

  typedef enum int {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    status_e            status;
    logic [InIdW-1:0]   req_id;
    logic [InFlowW-1:0] flow;
    logic [PtW-1:0]     cost;
  } sched_res_t;

  typedef struct {
    row_kind_e          kind;
    op_e                op;
    logic [InIdW-1:0]   req_id;
    logic [InFlowW-1:0] flow;
    logic [PtW-1:0]     cost;
    bit                 typed;
    sched_res_t         res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0, pop = 1'b0, full, empty;
  logic op_i = 1'b0;
  logic [InIdW-1:0] request_id_i = '0;
  logic [InFlowW-1:0] flow_index_i = '0;
  logic [PtW-1:0] processing_time_i = '0;
  logic [StatusW-1:0] status_o;
  logic [InIdW-1:0] out_request_id_o;
  logic [InFlowW-1:0] out_flow_o;
  logic [PtW-1:0] out_processing_time_o;
  logic cfg_valid_i = 1'b0, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [WeightW-1:0] cfg_data_i = '0;

  weighted_fair_queue_scheduler dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Scheduler mirror: weights, per-flow FIFOs, finish times and tag map
  logic [WeightW-1:0] wt[NFlows];
  logic [InIdW-1:0]   fifo_id[NFlows][QDepth];
  logic [PtW-1:0]     fifo_cost[NFlows][QDepth];
  int unsigned        q_head[NFlows], q_cnt[NFlows];
  logic [FtW-1:0]     finish_t[NFlows];
  bit                 tag_used[IdCount];
  int unsigned        tags_taken;

  sched_res_t  pending_res[$];
  idle_mode_e  idle_mode = IDLE_NONE;
  int unsigned mismatches, results_seen, items_sent, n_deq, n_full, n_dup;
  int unsigned hold_seq, cycles;

  function automatic sched_res_t schedule_step(op_e op, logic [InIdW-1:0] id,
                                               logic [InFlowW-1:0] fl, logic [PtW-1:0] pt);
    sched_res_t r;
    bit found;
    int unsigned pick, slot;
    logic [63:0] cand, best_t;
    r = '{status: ST_EMPTY, req_id: '0, flow: '0, cost: '0};
    found = 0;
    pick = 0;
    best_t = '0;
    if (op == OP_ENQ) begin
      if (tag_used[id]) r.status = ST_DUP;
      else if (fl >= NFlows || wt[fl] == '0) r.status = ST_ABSENT;
      else if (q_cnt[fl] >= QDepth) r.status = ST_FULL;
      else begin
        slot = (q_head[fl] + q_cnt[fl]) % QDepth;
        fifo_id[fl][slot] = id;
        fifo_cost[fl][slot] = pt;
        q_cnt[fl]++;
        tag_used[id] = 1;
        tags_taken++;
        r.status = ST_ENQ;
      end
      return r;
    end
    // Pick the smallest virtual finish time; ties go to the heavier flow
    for (int f = 0; f < NFlows; f++) begin
      if (wt[f] == '0 || q_cnt[f] == 0) continue;
      cand = 64'(finish_t[f]) + ((64'(fifo_cost[f][q_head[f]]) << Frac) / 64'(wt[f]));
      if (!found || cand < best_t) begin
        found = 1;
        pick = f;
        best_t = cand;
      end else if (cand == best_t && wt[f] > wt[pick]) begin
        pick = f;
      end
    end
    if (!found) return r;
    r.status = ST_DEQ;
    r.req_id = fifo_id[pick][q_head[pick]];
    r.flow = pick[InFlowW-1:0];
    r.cost = fifo_cost[pick][q_head[pick]];
    finish_t[pick] = (best_t > 64'(FtSat)) ? FtSat : best_t[FtW-1:0];
    q_head[pick] = (q_head[pick] + 1) % QDepth;
    q_cnt[pick]--;
    return r;
  endfunction

  // Offer one transaction; push stays high when the next one follows at once
  task automatic send_item(op_e op, logic [InIdW-1:0] id, logic [InFlowW-1:0] fl,
                           logic [PtW-1:0] pt, bit typed, sched_res_t typed_res);
    sched_res_t r;
    while ((idle_mode == IDLE_TX && $urandom_range(99) < 87) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 12)) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    op_i <= op;
    request_id_i <= id;
    flow_index_i <= fl;
    processing_time_i <= pt;
    do @(posedge clk_i); while (full);
    r = schedule_step(op, id, fl, pt);
    pending_res.push_back(typed ? typed_res : r);
    items_sent++;
    if (r.status == ST_DEQ) n_deq++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_DUP) n_dup++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // Write one weight register while the scheduler is idle
  task automatic write_weight(int unsigned idx, logic [WeightW-1:0] w);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx[CfgIdxW-1:0];
    cfg_data_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    wt[idx] = w;
  endtask

  function automatic logic [PtW-1:0] rand_cost();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? '1 : '0;
      1: return PtW'($urandom_range(15));
      default: return PtW'($urandom);
    endcase
  endfunction

  function automatic logic [InIdW-1:0] rand_tag(bit fresh);
    logic [InIdW-1:0] id;
    id = InIdW'($urandom);
    if (fresh && tags_taken < IdCount)
      while (tag_used[id]) id = InIdW'($urandom);
    return id;
  endfunction

  // Release results, honoring idling and the long hold-off
  always @(posedge clk_i) begin
    static int unsigned hold_left = 0, hold_seen = 0;
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldLen;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (idle_mode == IDLE_RX) pop <= ($urandom_range(99) >= 87);
    else if (idle_mode == IDLE_BOTH) pop <= ($urandom_range(99) >= 12);
    else pop <= 1'b1;
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    sched_res_t want, got;
    if (rst_ni && pop && !empty) begin
      got = '{status: status_e'(status_o), req_id: out_request_id_o,
              flow: out_flow_o, cost: out_processing_time_o};
      results_seen++;
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected %p, got %p", results_seen, want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_res.size());
      $display("tb_weighted_fair_queue_scheduler: FAIL");
      $finish;
    end
  end

  stim_row_t dir_rows[$];
  const sched_res_t NoRes = '{status: ST_ENQ, req_id: '0, flow: '0, cost: '0};

  function automatic stim_row_t mk(row_kind_e k, op_e op, int id, int fl, int pt,
                                   bit typed = 0, status_e st = ST_ENQ);
    stim_row_t s;
    s = '{kind: k, op: op, req_id: InIdW'(id), flow: InFlowW'(fl), cost: PtW'(pt),
          typed: typed, res: '{status: st, req_id: '0, flow: '0, cost: '0}};
    return s;
  endfunction

  initial begin
    logic [WeightW-1:0] pw[4];
    for (int f = 0; f < NFlows; f++) begin
      wt[f] = '0; q_head[f] = 0; q_cnt[f] = 0; finish_t[f] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: empty and absent after reset, weight extremes, duplicate tag,
    // absent flow, zero weight while requests wait and its return
    dir_rows = '{
      mk(ROW_ITEM, OP_DEQ, 0, 0, 0, 1, ST_EMPTY),
      mk(ROW_ITEM, OP_ENQ, 9, 0, 5, 1, ST_ABSENT),
      mk(ROW_CFG, OP_ENQ, 0, 0, 1),
      mk(ROW_CFG, OP_ENQ, 1, 0, 65535),
      mk(ROW_CFG, OP_ENQ, 2, 0, 2),
      mk(ROW_ITEM, OP_ENQ, 0, 0, 65535, 1, ST_ENQ),
      mk(ROW_ITEM, OP_ENQ, 0, 1, 7, 1, ST_DUP),
      mk(ROW_ITEM, OP_ENQ, 255, 3, 7, 1, ST_ABSENT),
      mk(ROW_ITEM, OP_ENQ, 1, 1, 0),
      mk(ROW_ITEM, OP_ENQ, 2, 2, 65535),
      mk(ROW_ITEM, OP_ENQ, 3, 1, 1),
      mk(ROW_ITEM, OP_DEQ, 170, 2, 4660),
      mk(ROW_ITEM, OP_DEQ, 0, 0, 0),
      mk(ROW_ITEM, OP_DEQ, 0, 0, 0),
      mk(ROW_ITEM, OP_DEQ, 0, 0, 0),
      mk(ROW_ITEM, OP_DEQ, 0, 0, 0, 1, ST_EMPTY),
      mk(ROW_ITEM, OP_ENQ, 4, 1, 100),
      mk(ROW_CFG, OP_ENQ, 1, 0, 0),
      mk(ROW_ITEM, OP_DEQ, 0, 0, 0, 1, ST_EMPTY),
      mk(ROW_CFG, OP_ENQ, 1, 0, 7),
      mk(ROW_ITEM, OP_DEQ, 0, 0, 0)
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_weight(dir_rows[i].req_id, dir_rows[i].cost);
      else send_item(dir_rows[i].op, dir_rows[i].req_id, dir_rows[i].flow,
                     dir_rows[i].cost, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random phases, each with its own weights and idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: pw = '{16'hFFFF, 16'd1, 16'd300, 16'd0};
        1: pw = '{WeightW'($urandom), WeightW'($urandom_range(9)),
                  WeightW'($urandom), WeightW'($urandom_range(1) * 12)};
        2: pw = '{16'd5, 16'd5, 16'd5, 16'd5};
        default: pw = '{WeightW'($urandom_range(3)), 16'hFFFF,
                        WeightW'($urandom), 16'd1};
      endcase
      for (int f = 0; f < NFlows; f++) write_weight(f, pw[f]);
      idle_mode = idle_mode_e'(ph);
      if (ph == 0) begin
        // Hold off the receiver and overfill the heaviest flow's queue
        hold_seq++;
        for (int k = 0; k <= QDepth; k++)
          send_item(OP_ENQ, rand_tag(1), 0, rand_cost(), 0, NoRes);
      end
      for (int k = 0; k < RandItems; k++) begin
        if ($urandom_range(1)) send_item(OP_DEQ, InIdW'($urandom), InFlowW'($urandom),
                                         PtW'($urandom), 0, NoRes);
        else send_item(OP_ENQ, rand_tag($urandom_range(99) < 30), InFlowW'($urandom),
                       rand_cost(), 0, NoRes);
      end
    end
    drain();

    $display("covered %0d transactions: %0d dequeued, %0d queue-full, %0d duplicate tags",
             items_sent, n_deq, n_full, n_dup);
    $display("four weight settings and four idling patterns; %0d mismatches", mismatches);
    if (mismatches == 0) $display("tb_weighted_fair_queue_scheduler: PASS");
    else $display("tb_weighted_fair_queue_scheduler: FAIL");
    $finish;
  end

endmodule
